// ===== design/orl_pkg.sv =====
// ----------------------------------------------------------------------------
// orl_pkg
// Shared types and constants for the ordered record list unit: action and
// status codes, item and result payloads, cell command and FSM state.
// ----------------------------------------------------------------------------
package orl_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int IDX_MAX_W    = 6;   // index width at the largest capacity
    localparam int CNT_MAX_W    = 7;   // count width at the largest capacity
    localparam int MAX_RESULTS  = 32;  // list all stops after this many records

    localparam logic [5:0] CAP_RESET = 6'd32;

    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_DELETE = 3'd1,
        ACT_SEARCH = 3'd2,
        ACT_UPDATE = 3'd3,
        ACT_READ   = 3'd4,
        ACT_CLEAR  = 3'd5,
        ACT_LIST   = 3'd6
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef struct packed {
        action_t     action;
        logic [5:0]  position;
        logic [63:0] lookup_key;
        logic [63:0] new_name;
        logic [63:0] new_ident;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  found_index;
        logic [63:0] record_name;
        logic [63:0] record_ident;
        logic [5:0]  record_count;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic [63:0] name;
        logic [63:0] ident;
    } cell_data_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_WRITE  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t               op;
        logic [IDX_MAX_W-1:0]   target;
        cell_data_t             wr;
        logic                   cmp_en;
        logic [63:0]            key;
        logic [CNT_MAX_W-1:0]   count;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_LIST = 2'd2
    } state_t;

endpackage

// ===== design/orl_cell.sv =====
// ----------------------------------------------------------------------------
// orl_cell
// One list slot. Holds a record, compares it against a broadcast key and
// takes data from its left neighbor (insert) or right neighbor (delete).
// ----------------------------------------------------------------------------
module orl_cell #(
    parameter int INDEX = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  orl_pkg::cell_cmd_t  cmd,
    input  orl_pkg::cell_data_t left,
    input  orl_pkg::cell_data_t right,
    output orl_pkg::cell_data_t data,
    output logic                match
);

    localparam int IW = orl_pkg::IDX_MAX_W;
    localparam int CW = orl_pkg::CNT_MAX_W;
    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    orl_pkg::cell_data_t data_reg;
    orl_pkg::cell_data_t data_next;
    logic                match_reg;
    logic                match_next;

    always_comb
    begin
        match_next = cmd.cmp_en && (CW'(MY_IDX) < cmd.count) &&
                     ((data_reg.name == cmd.key) || (data_reg.ident == cmd.key));

        data_next = data_reg;
        case (cmd.op)
            orl_pkg::CELL_INSERT:
            begin
                if (MY_IDX == cmd.target)
                    data_next = cmd.wr;
                else if (MY_IDX > cmd.target)
                    data_next = left;
            end
            orl_pkg::CELL_DELETE:
            begin
                if (MY_IDX >= cmd.target)
                    data_next = right;
            end
            orl_pkg::CELL_WRITE:
            begin
                if (MY_IDX == cmd.target)
                    data_next = cmd.wr;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            match_reg <= 1'b0;
        else
            match_reg <= match_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

// ===== design/orl_readout.sv =====
// ----------------------------------------------------------------------------
// orl_readout
// One-hot readout of the cell row: returns the selected record and its
// position.
// ----------------------------------------------------------------------------
module orl_readout #(
    parameter int N  = orl_pkg::CAPACITY_DEF,
    parameter int IW = 5
) (
    input  logic [N-1:0]                sel,
    input  orl_pkg::cell_data_t [N-1:0] cells,
    output orl_pkg::cell_data_t         rd_data,
    output logic [IW-1:0]               rd_index
);

    always_comb
    begin
        rd_data  = '0;
        rd_index = '0;
        for (int i = 0; i < N; i++)
        begin
            if (sel[i])
            begin
                rd_data.name  = rd_data.name | cells[i].name;
                rd_data.ident = rd_data.ident | cells[i].ident;
                rd_index      = rd_index | IW'(i);
            end
        end
    end

endmodule

// ===== design/ordered_record_list_unit.sv =====
// ----------------------------------------------------------------------------
// ordered_record_list_unit
// Ordered record list held in a row of cells. For each item, the accept
// cycle registers the key compare in every cell, the next cycle shifts or
// writes the row and registers the result, which then shows on the outputs.
// List all then streams one record per cycle while busy.
// Reset clears the count and sets the capacity to 32; records stay undefined
// until written. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module ordered_record_list_unit #(
    parameter int CAPACITY = orl_pkg::CAPACITY_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  orl_pkg::item_t   item,
    output logic             result_valid,
    output orl_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [5:0]       cfg_data
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = 8;   // common compare width

    orl_pkg::state_t             state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [IDX_W-1:0]            list_reg, list_next;
    logic [5:0]                  cap_reg;
    orl_pkg::item_t              item_reg;
    orl_pkg::result_t            result_reg, result_next;
    logic                        strobe_reg, strobe_next;

    orl_pkg::cell_cmd_t          cell_cmd;
    orl_pkg::cell_data_t [CAPACITY-1:0] cell_data;
    orl_pkg::cell_data_t [CAPACITY-1:0] left_in;
    orl_pkg::cell_data_t [CAPACITY-1:0] right_in;
    logic [CAPACITY-1:0]         match_vec;
    logic [CAPACITY-1:0]         first_hit;
    logic [CAPACITY-1:0]         pos_dec;
    logic [CAPACITY-1:0]         list_dec;
    logic [CAPACITY-1:0]         sel;
    orl_pkg::cell_data_t         rd_data;
    logic [IDX_W-1:0]            rd_index;

    logic                        accept;
    logic                        found;
    logic [CW-1:0]               pos_w, cnt_w, lim_w, next_w;

    assign busy      = (state_reg != orl_pkg::S_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = !busy;

    // ---------------- cell row ----------------
    always_comb
    begin
        left_in  = '0;
        right_in = '0;
        for (int i = 1; i < CAPACITY; i++)
        begin
            left_in[i]      = cell_data[i-1];
            right_in[i-1]   = cell_data[i];
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        orl_cell #(
            .INDEX (g)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cell_cmd),
            .left  (left_in[g]),
            .right (right_in[g]),
            .data  (cell_data[g]),
            .match (match_vec[g])
        );
    end

    orl_readout #(
        .N  (CAPACITY),
        .IW (IDX_W)
    ) u_readout (
        .sel      (sel),
        .cells    (cell_data),
        .rd_data  (rd_data),
        .rd_index (rd_index)
    );

    // ---------------- selection ----------------
    assign first_hit = match_vec & (~match_vec + CAPACITY'(1));
    assign found     = |match_vec;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            pos_dec[i]  = (item_reg.position == 6'(i));
            list_dec[i] = (list_reg == IDX_W'(i));
        end
    end

    always_comb
    begin
        if (state_reg == orl_pkg::S_LIST)
            sel = list_dec;
        else if (item_reg.action == orl_pkg::ACT_READ)
            sel = pos_dec;
        else
            sel = first_hit;
    end

    assign pos_w  = CW'(item_reg.position);
    assign cnt_w  = CW'(count_reg);
    assign lim_w  = (CW'(cap_reg) < CW'(CAPACITY)) ? CW'(cap_reg) : CW'(CAPACITY);
    assign next_w = CW'(list_reg) + CW'(1);

    // ---------------- control ----------------
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        list_next   = list_reg;
        strobe_next = 1'b0;
        result_next = '0;
        result_next.last_of_run = 1'b1;

        cell_cmd        = '0;
        cell_cmd.op     = orl_pkg::CELL_HOLD;
        cell_cmd.key    = item.lookup_key;
        cell_cmd.count  = orl_pkg::CNT_MAX_W'(count_reg);
        cell_cmd.wr.name  = item_reg.new_name;
        cell_cmd.wr.ident = item_reg.new_ident;

        case (state_reg)
            orl_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cell_cmd.cmp_en = 1'b1;
                    state_next      = orl_pkg::S_EXEC;
                end
            end
            orl_pkg::S_EXEC:
            begin
                state_next  = orl_pkg::S_IDLE;
                strobe_next = 1'b1;
                case (item_reg.action)
                    orl_pkg::ACT_INSERT:
                    begin
                        if (pos_w > cnt_w)
                            result_next.status = orl_pkg::ST_BAD_POS;
                        else if (cnt_w >= lim_w)
                            result_next.status = orl_pkg::ST_FULL;
                        else
                        begin
                            cell_cmd.op     = orl_pkg::CELL_INSERT;
                            cell_cmd.target = orl_pkg::IDX_MAX_W'(item_reg.position);
                            count_next      = count_reg + CNT_W'(1);
                            result_next.status       = orl_pkg::ST_OK;
                            result_next.found_index  = 5'(item_reg.position);
                            result_next.record_name  = item_reg.new_name;
                            result_next.record_ident = item_reg.new_ident;
                        end
                    end
                    orl_pkg::ACT_DELETE:
                    begin
                        if (found)
                        begin
                            cell_cmd.op     = orl_pkg::CELL_DELETE;
                            cell_cmd.target = orl_pkg::IDX_MAX_W'(rd_index);
                            count_next      = count_reg - CNT_W'(1);
                            result_next.status       = orl_pkg::ST_OK;
                            result_next.found_index  = 5'(rd_index);
                            result_next.record_name  = rd_data.name;
                            result_next.record_ident = rd_data.ident;
                        end
                        else
                            result_next.status = orl_pkg::ST_NOT_FOUND;
                    end
                    orl_pkg::ACT_SEARCH:
                    begin
                        if (found)
                        begin
                            result_next.status       = orl_pkg::ST_OK;
                            result_next.found_index  = 5'(rd_index);
                            result_next.record_name  = rd_data.name;
                            result_next.record_ident = rd_data.ident;
                        end
                        else
                            result_next.status = orl_pkg::ST_NOT_FOUND;
                    end
                    orl_pkg::ACT_UPDATE:
                    begin
                        if (found)
                        begin
                            cell_cmd.op     = orl_pkg::CELL_WRITE;
                            cell_cmd.target = orl_pkg::IDX_MAX_W'(rd_index);
                            result_next.status       = orl_pkg::ST_OK;
                            result_next.found_index  = 5'(rd_index);
                            result_next.record_name  = item_reg.new_name;
                            result_next.record_ident = item_reg.new_ident;
                        end
                        else
                            result_next.status = orl_pkg::ST_NOT_FOUND;
                    end
                    orl_pkg::ACT_READ:
                    begin
                        if (pos_w < cnt_w)
                        begin
                            result_next.status       = orl_pkg::ST_OK;
                            result_next.found_index  = 5'(rd_index);
                            result_next.record_name  = rd_data.name;
                            result_next.record_ident = rd_data.ident;
                        end
                        else
                            result_next.status = orl_pkg::ST_BAD_POS;
                    end
                    orl_pkg::ACT_CLEAR:
                    begin
                        count_next         = '0;
                        result_next.status = orl_pkg::ST_OK;
                    end
                    orl_pkg::ACT_LIST:
                    begin
                        if (count_reg == '0)
                            result_next.status = orl_pkg::ST_NOT_FOUND;
                        else
                        begin
                            strobe_next = 1'b0;
                            list_next   = '0;
                            state_next  = orl_pkg::S_LIST;
                        end
                    end
                    default:
                    begin
                        result_next.status = orl_pkg::ST_OK;
                    end
                endcase
                result_next.record_count = 6'(count_next);
            end
            orl_pkg::S_LIST:
            begin
                strobe_next = 1'b1;
                result_next.status       = orl_pkg::ST_OK;
                result_next.found_index  = 5'(rd_index);
                result_next.record_name  = rd_data.name;
                result_next.record_ident = rd_data.ident;
                result_next.record_count = 6'(count_reg);
                result_next.last_of_run  = (next_w == cnt_w) ||
                                           (next_w == CW'(orl_pkg::MAX_RESULTS));
                if (result_next.last_of_run)
                    state_next = orl_pkg::S_IDLE;
                else
                    list_next = list_reg + IDX_W'(1);
            end
            default:
            begin
                state_next = orl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= orl_pkg::S_IDLE;
            count_reg  <= '0;
            list_reg   <= '0;
            strobe_reg <= 1'b0;
            cap_reg    <= orl_pkg::CAP_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            list_reg   <= list_next;
            strobe_reg <= strobe_next;
            if (cfg_valid && cfg_ready)
                cap_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item;
        result_reg <= result_next;
    end

    assign result_valid = strobe_reg;
    assign result       = result_reg;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(count_reg) <= CW'(CAPACITY))
        else $error("record count above capacity");

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result transfer without work in progress");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy && !result_valid))
        else $error("accepted item did not start execution");

    a_list_streams: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == orl_pkg::S_LIST) |=> result_valid)
        else $error("list all skipped a cycle");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status != orl_pkg::ST_OK)) |->
            ((result.record_name == '0) && (result.record_ident == '0) &&
             (result.found_index == '0)))
        else $error("failed result carries record data");

endmodule

// ===== tb/ordered_record_list_unit_tb.sv =====
// ----------------------------------------------------------------------------
// ordered_record_list_unit_tb
// Self-checking bench for the ordered record list unit. A queued driver issues
// list actions and capacity writes. A shadow copy of the list predicts every
// result, and a monitor checks each strobed result in order, field by field.
// ----------------------------------------------------------------------------
module ordered_record_list_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import orl_pkg::*;

    localparam int      LIST_CAP      = 32;
    localparam int      DRAIN_CYCLES  = 4;
    localparam int      END_CYCLES    = 10;
    localparam int      STALL_LIMIT   = 2000;
    localparam action_t ACT_UNDEFINED = action_t'(3'd7);

    typedef enum logic [1:0] {
        STEP_ITEM  = 2'd0,
        STEP_CFG   = 2'd1,
        STEP_PAUSE = 2'd2,
        STEP_IDLE  = 2'd3
    } step_kind_t;

    typedef struct packed {
        step_kind_t  kind;
        item_t       payload;
        logic [5:0]  cap_value;
        logic [7:0]  idle_cycles;
    } step_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    logic        busy;
    item_t       item      = '0;
    logic        result_valid;
    result_t     result;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [5:0]  cfg_data  = '0;

    step_t       pending_steps[$];
    result_t     expected_results[$];
    logic [63:0] held_name [LIST_CAP];
    logic [63:0] held_ident[LIST_CAP];
    int          held_count   = 0;
    logic [5:0]  cap_reg      = CAP_RESET;
    int          idle_left    = 0;
    int          quiet_cycles = 0;
    int          stall_cycles = 0;
    int          error_count  = 0;
    logic        gaps_on      = 1'b1;
    logic [63:0] value_pool[16];

    ordered_record_list_unit #(
        .CAPACITY(LIST_CAP)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .result_valid(result_valid),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic flag_error(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(string fname, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            flag_error($sformatf("%s got %h expected %h", fname, got, want));
    endtask

    // Applies one action to the shadow list and queues the results it yields.
    function automatic void predict_list_results(item_t it);
        result_t r;
        int      lim;
        int      hit;
        int      p;
        lim = (cap_reg < LIST_CAP) ? cap_reg : LIST_CAP;
        hit = -1;
        for (p = 0; p < held_count; p++)
            if (hit < 0 && (held_name[p] == it.lookup_key || held_ident[p] == it.lookup_key))
                hit = p;
        r = '0;
        r.last_of_run = 1'b1;
        case (it.action)
            ACT_INSERT:
            begin
                // position is checked before fullness
                if (it.position > held_count)
                    r.status = ST_BAD_POS;
                else if (held_count >= lim)
                    r.status = ST_FULL;
                else
                begin
                    for (p = held_count; p > it.position; p--)
                    begin
                        held_name[p]  = held_name[p-1];
                        held_ident[p] = held_ident[p-1];
                    end
                    held_name[it.position]  = it.new_name;
                    held_ident[it.position] = it.new_ident;
                    held_count++;
                    r.status       = ST_OK;
                    r.found_index  = it.position[4:0];
                    r.record_name  = it.new_name;
                    r.record_ident = it.new_ident;
                end
            end
            ACT_DELETE:
            begin
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    r.found_index  = hit[4:0];
                    r.record_name  = held_name[hit];
                    r.record_ident = held_ident[hit];
                    for (p = hit; p + 1 < held_count; p++)
                    begin
                        held_name[p]  = held_name[p+1];
                        held_ident[p] = held_ident[p+1];
                    end
                    held_count--;
                end
            end
            ACT_SEARCH, ACT_UPDATE:
            begin
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    if (it.action == ACT_UPDATE)
                    begin
                        held_name[hit]  = it.new_name;
                        held_ident[hit] = it.new_ident;
                    end
                    r.found_index  = hit[4:0];
                    r.record_name  = held_name[hit];
                    r.record_ident = held_ident[hit];
                end
            end
            ACT_READ:
            begin
                if (it.position < held_count)
                begin
                    r.found_index  = it.position[4:0];
                    r.record_name  = held_name[it.position];
                    r.record_ident = held_ident[it.position];
                end
                else
                    r.status = ST_BAD_POS;
            end
            ACT_CLEAR:
                held_count = 0;
            ACT_LIST:
            begin
                if (held_count == 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    // one result per record, only the final one marked
                    for (p = 0; p < held_count; p++)
                    begin
                        r.found_index  = p[4:0];
                        r.record_name  = held_name[p];
                        r.record_ident = held_ident[p];
                        r.record_count = held_count[5:0];
                        r.last_of_run  = (p + 1 == held_count);
                        expected_results.push_back(r);
                    end
                    return;
                end
            end
            default:
                r.status = ST_OK;
        endcase
        r.record_count = held_count[5:0];
        expected_results.push_back(r);
    endfunction

    // Driver: walks the step queue, holds start and cfg_valid until each transfer.
    always @(posedge clk or negedge rst_n)
    begin : driver_proc
        step_t nxt;
        logic  hold_start;
        logic  hold_cfg;
        logic  next_start;
        logic  next_cfg;
        logic  drained;
        if (!rst_n)
        begin
            start     <= 1'b0;
            item      <= '0;
            cfg_valid <= 1'b0;
            cfg_data  <= '0;
            idle_left    = 0;
            quiet_cycles = 0;
        end
        else
        begin
            hold_start = start && busy;
            hold_cfg   = cfg_valid && !cfg_ready;
            if (start && !busy)
                predict_list_results(item);
            if (cfg_valid && cfg_ready)
                cap_reg = cfg_data;
            if ((start && !busy) || result_valid)
                quiet_cycles = 0;
            else if (quiet_cycles < STALL_LIMIT)
                quiet_cycles++;
            drained = (expected_results.size() == 0) && !busy &&
                      (quiet_cycles >= DRAIN_CYCLES);
            next_start = hold_start;
            next_cfg   = hold_cfg;
            if (!hold_start && !hold_cfg)
            begin
                if (idle_left > 0)
                    idle_left--;
                else if (pending_steps.size() != 0)
                begin
                    nxt = pending_steps[0];
                    case (nxt.kind)
                        STEP_ITEM:
                        begin
                            void'(pending_steps.pop_front());
                            item       <= nxt.payload;
                            next_start = 1'b1;
                        end
                        STEP_CFG:
                            if (drained)
                            begin
                                void'(pending_steps.pop_front());
                                cfg_data <= nxt.cap_value;
                                next_cfg = 1'b1;
                            end
                        STEP_PAUSE:
                            if (drained)
                                void'(pending_steps.pop_front());
                        default:
                        begin
                            void'(pending_steps.pop_front());
                            idle_left = int'(nxt.idle_cycles);
                        end
                    endcase
                end
            end
            start     <= next_start;
            cfg_valid <= next_cfg;
        end
    end

    always @(posedge clk)
    begin : monitor_proc
        result_t want;
        if (rst_n && result_valid === 1'b1)
        begin
            if (expected_results.size() == 0)
                flag_error($sformatf("unexpected result %h", result));
            else
            begin
                want = expected_results.pop_front();
                compare_field("status",       64'(result.status),      64'(want.status));
                compare_field("found_index",  64'(result.found_index), 64'(want.found_index));
                compare_field("record_name",  result.record_name,      want.record_name);
                compare_field("record_ident", result.record_ident,     want.record_ident);
                compare_field("record_count", 64'(result.record_count),
                              64'(want.record_count));
                compare_field("last_of_run",  64'(result.last_of_run), 64'(want.last_of_run));
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic queue_item(action_t act, logic [5:0] pos, logic [63:0] key,
                              logic [63:0] nm, logic [63:0] id);
        step_t s;
        s = '0;
        if (gaps_on && $urandom_range(0, 99) < 33)
        begin
            s.kind        = STEP_IDLE;
            s.idle_cycles = 8'($urandom_range(1, 4));
            pending_steps.push_back(s);
        end
        s = '0;
        s.kind               = STEP_ITEM;
        s.payload.action     = act;
        s.payload.position   = pos;
        s.payload.lookup_key = key;
        s.payload.new_name   = nm;
        s.payload.new_ident  = id;
        pending_steps.push_back(s);
    endtask

    task automatic queue_cfg(logic [5:0] value);
        step_t s;
        s = '0;
        s.kind      = STEP_CFG;
        s.cap_value = value;
        pending_steps.push_back(s);
    endtask

    task automatic queue_pause();
        step_t s;
        s = '0;
        s.kind = STEP_PAUSE;
        pending_steps.push_back(s);
    endtask

    // Mostly values from a small pool so keys hit stored records.
    function automatic logic [63:0] pool_value();
        if ($urandom_range(0, 9) < 8)
            return value_pool[4'($urandom_range(0, 15))];
        return {$urandom, $urandom};
    endfunction

    task automatic queue_random_item();
        int         pick;
        action_t    act;
        logic [5:0] pos;
        pick = $urandom_range(0, 99);
        if (pick < 34)
            act = ACT_INSERT;
        else if (pick < 50)
            act = ACT_DELETE;
        else if (pick < 62)
            act = ACT_SEARCH;
        else if (pick < 72)
            act = ACT_UPDATE;
        else if (pick < 85)
            act = ACT_READ;
        else if (pick < 92)
            act = ACT_LIST;
        else if (pick < 96)
            act = ACT_CLEAR;
        else
            act = ACT_UNDEFINED;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            pos = 6'($urandom_range(0, 12));
        else if (pick < 9)
            pos = 6'($urandom_range(0, 32));
        else
            pos = 6'($urandom_range(0, 63));
        queue_item(act, pos, pool_value(), pool_value(), pool_value());
    endtask

    initial
    begin : stimulus
        int i;
        for (i = 0; i < 16; i++)
            value_pool[i] = {$urandom, $urandom};
        value_pool[0] = '1;
        value_pool[1] = '0;

        // empty list cases
        queue_item(ACT_LIST,   6'd0, value_pool[2], value_pool[3], value_pool[4]);
        queue_item(ACT_READ,   6'd0, value_pool[2], value_pool[3], value_pool[4]);
        queue_item(ACT_DELETE, 6'd0, value_pool[2], value_pool[3], value_pool[4]);
        queue_item(ACT_INSERT, 6'd1, value_pool[2], value_pool[3], value_pool[4]);
        // build four records, inserted at the head and at the end
        queue_item(ACT_INSERT, 6'd0, '0, '1, '0);
        queue_item(ACT_INSERT, 6'd1, '0, value_pool[2], value_pool[3]);
        queue_item(ACT_INSERT, 6'd0, '0, value_pool[4], value_pool[5]);
        queue_item(ACT_INSERT, 6'd3, '0, value_pool[6], '1);
        queue_item(ACT_SEARCH, 6'd0, value_pool[3], '0, '0);
        queue_item(ACT_SEARCH, 6'd0, '1, '0, '0);
        queue_item(ACT_SEARCH, 6'd0, value_pool[4], '0, '0);
        queue_item(ACT_UPDATE, 6'd0, value_pool[6], value_pool[7], value_pool[8]);
        queue_item(ACT_READ,   6'd3, '0, '0, '0);
        queue_item(ACT_READ,   6'd63, '1, '1, '1);
        queue_item(ACT_READ,   6'd4, '0, '0, '0);
        queue_item(ACT_DELETE, 6'd0, value_pool[5], '0, '0);
        queue_item(ACT_SEARCH, 6'd0, value_pool[5], '0, '0);
        queue_item(ACT_UNDEFINED, 6'd42, {$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom});
        queue_item(ACT_LIST,   6'd0, '0, '0, '0);
        queue_item(ACT_CLEAR,  6'd0, '0, '0, '0);
        queue_item(ACT_LIST,   6'd0, '0, '0, '0);
        // capacity of one, then zero
        queue_cfg(6'd1);
        queue_item(ACT_INSERT, 6'd0, '0, value_pool[9], value_pool[10]);
        queue_item(ACT_INSERT, 6'd0, '0, value_pool[11], value_pool[12]);
        queue_cfg(6'd0);
        queue_item(ACT_INSERT, 6'd0, '0, value_pool[13], value_pool[14]);
        queue_item(ACT_INSERT, 6'd63, '0, value_pool[13], value_pool[14]);

        // fill to the top without gaps: capacity above the list size
        queue_cfg(6'd63);
        gaps_on = 1'b0;
        queue_item(ACT_CLEAR, 6'd0, '0, '0, '0);
        for (i = 0; i <= LIST_CAP; i++)
            queue_item(ACT_INSERT, 6'($urandom_range(0, i)), '0, pool_value(), pool_value());
        queue_item(ACT_LIST, 6'd0, '0, '0, '0);
        for (i = 0; i < 8; i++)
            queue_random_item();
        gaps_on = 1'b1;

        // capacity lowered below the records held
        queue_cfg(6'd2);
        queue_item(ACT_INSERT, 6'd0, '0, pool_value(), pool_value());
        for (i = 0; i < 20; i++)
            queue_random_item();
        queue_pause();
        queue_cfg(6'd32);
        for (i = 0; i < 15; i++)
            queue_random_item();
        queue_pause();
        for (i = 0; i < 15; i++)
            queue_random_item();
        queue_cfg(6'd7);
        for (i = 0; i < 20; i++)
            queue_random_item();
        queue_cfg(6'd31);
        for (i = 0; i < 10; i++)
            queue_random_item();

        @(posedge clk);
        while (pending_steps.size() != 0 || start || cfg_valid ||
               expected_results.size() != 0)
            @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
            flag_error($sformatf("%0d expected results never arrived",
                                 expected_results.size()));
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
